// ===== rtl/range_frame_safe_direction_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Range frame safe direction: assertion macros
// Shared property forms for the concurrent checks of the unit, clocked on clk
// and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RANGE_FRAME_SAFE_DIRECTION_UNIT_ASSERT_SVH
`define RANGE_FRAME_SAFE_DIRECTION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RFSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Range frame safe direction package
// Frame codes, CORDIC constants, widths and the elaboration-time unit vector
// function used to build the sensor direction tables.
// ----------------------------------------------------------------------------
package rfsd_pkg;

	localparam int unsigned DIST_W = 8;
	localparam int unsigned DIR_W  = 9;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned UNIT_W = 16;
	localparam int unsigned ACC_W  = 34;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [DIST_W-1:0] FRAME_HEADER  = 8'hFF;
	localparam logic [DIST_W-1:0] FRAME_TRAILER = 8'hAA;
	localparam logic [DIST_W-1:0] LIMIT_RESET   = 8'hFF;

	localparam int unsigned CORDIC_STEPS    = 20;
	localparam int unsigned VEC_SCALE_SHIFT = 20;
	localparam int unsigned STEP_W          = $clog2(CORDIC_STEPS);

	localparam logic signed [ACC_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic [8:0] DEG_PER_TURN = 9'd360;

	localparam logic [DIR_W-1:0] DEG_LIMIT = 9'd180;
	localparam logic signed [DIR_W-1:0] DIR_ZERO    = 9'sd0;
	localparam logic signed [DIR_W-1:0] DIR_HALF    = 9'sd180;
	localparam logic signed [DIR_W-1:0] DIR_QUARTER = 9'sd90;

	localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
		32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
	};

	localparam logic signed [63:0] HALF_TURN_64  = 64'sd2147483648;
	localparam logic signed [63:0] FULL_TURN_64  = 64'sd4294967296;
	localparam logic signed [63:0] QUART_TURN_64 = 64'sd1073741824;
	localparam logic signed [63:0] INV_GAIN_64   = 64'sd652032874;
	localparam logic signed [63:0] ROUND_HALF_64 = 64'sd32768;

	// Cosine and sine of a binary angle in Q2.14, packed as {cos, sin}.
	// Evaluated at elaboration only; the rotation follows the fixed-point
	// CORDIC exactly so the tables match bit for bit.
	function automatic logic [2*UNIT_W-1:0] unit_vec(input logic [31:0] ang);
		logic signed [63:0] z;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		logic flip;
		z = $signed({32'd0, ang});
		x = INV_GAIN_64;
		y = 64'sd0;
		flip = 1'b0;
		if (z >= HALF_TURN_64) begin
			z = z - FULL_TURN_64;
		end
		if (z > QUART_TURN_64) begin
			z = z - HALF_TURN_64;
			flip = 1'b1;
		end else if (z < -QUART_TURN_64) begin
			z = z + HALF_TURN_64;
			flip = 1'b1;
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - $signed({32'd0, TURN_ATAN[k]});
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + $signed({32'd0, TURN_ATAN[k]});
			end
		end
		x = (x + ROUND_HALF_64) >>> 16;
		y = (y + ROUND_HALF_64) >>> 16;
		if (flip) begin
			x = -x;
			y = -y;
		end
		return {x[UNIT_W-1:0], y[UNIT_W-1:0]};
	endfunction

endpackage

// ===== rtl/rfsd_byte_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one byte from the sensor link per beat.
// ----------------------------------------------------------------------------
interface rfsd_byte_if import rfsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/rfsd_dir_if.sv =====
// ----------------------------------------------------------------------------
// Direction result channel
// Valid/ready channel carrying one frame result per beat.
// ----------------------------------------------------------------------------
interface rfsd_dir_if import rfsd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DIR_W-1:0] safe_direction;
	logic [IDX_W-1:0]        nearest_sensor;

	modport source (output valid, output safe_direction, output nearest_sensor, input ready);
	modport sink   (input valid, input safe_direction, input nearest_sensor, output ready);
endinterface

// ===== rtl/rfsd_front.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Hunts for the header, gathers the distance bytes and hands a complete frame
// to the queue when the trailer checks out.
// ----------------------------------------------------------------------------
module rfsd_front import rfsd_pkg::*; #(
	parameter int unsigned NUM_SENSORS = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rfsd_byte_if.sink                           rx,
	output logic                                push_valid,
	input  logic                                push_ready,
	output logic [NUM_SENSORS-1:0][DIST_W-1:0]  push_frame
);

	localparam int unsigned POS_W = $clog2(NUM_SENSORS + 2);
	localparam logic [POS_W-1:0] POS_IDLE    = '0;
	localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(1);
	localparam logic [POS_W-1:0] TRAILER_POS = POS_W'(NUM_SENSORS + 1);

	logic [POS_W-1:0]                pos_q;
	logic [NUM_SENSORS-1:0][DIST_W-1:0] frame_q;
	logic                            take;

	// Only the trailer beat needs room in the queue.
	assign rx.ready   = !((pos_q == TRAILER_POS) && !push_ready);
	assign take       = rx.valid && rx.ready;
	assign push_valid = take && (pos_q == TRAILER_POS) && (rx.rx_byte == FRAME_TRAILER);
	assign push_frame = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (take) begin
			if (pos_q == POS_IDLE) begin
				pos_q <= (rx.rx_byte == FRAME_HEADER) ? POS_FIRST : POS_IDLE;
			end else if (pos_q == TRAILER_POS) begin
				pos_q <= POS_IDLE;
			end else begin
				pos_q <= pos_q + POS_FIRST;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (take && (pos_q == POS_W'(i + 1))) begin
				frame_q[i] <= rx.rx_byte;
			end
		end
	end

endmodule

// ===== rtl/rfsd_queue.sv =====
// ----------------------------------------------------------------------------
// Frame queue
// Two-entry first-in first-out buffer of complete frames between the parser
// and the direction engine.
// ----------------------------------------------------------------------------
module rfsd_queue import rfsd_pkg::*; #(
	parameter int unsigned WIDTH = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/rfsd_back.sv =====
// ----------------------------------------------------------------------------
// Direction engine
// Takes one frame at a time: accumulates the clamped vector sum and the
// nearest sensor one sensor per cycle, then, unless the sum lies on an axis,
// runs a CORDIC vectoring pass and converts the angle to whole degrees.
// ----------------------------------------------------------------------------
module rfsd_back import rfsd_pkg::*; #(
	parameter int unsigned NUM_SENSORS = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  logic [NUM_SENSORS-1:0][DIST_W-1:0] pop_frame,
	input  logic [DIST_W-1:0]                  distance_limit,
	rfsd_dir_if.source                         res
);

	localparam int unsigned SEL_W  = $clog2(NUM_SENSORS);
	localparam int unsigned PROD_W = DIST_W + 1 + UNIT_W;
	localparam int unsigned SUM_W  = PROD_W + $clog2(NUM_SENSORS);
	localparam int unsigned CW     = SUM_W + VEC_SCALE_SHIFT + 2;
	localparam logic [SEL_W-1:0]  SEL_LAST  = SEL_W'(NUM_SENSORS - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_PREP,
		S_ROT,
		S_DEG,
		S_OUT
	} state_t;

	logic signed [UNIT_W-1:0] cos_tab [NUM_SENSORS];
	logic signed [UNIT_W-1:0] sin_tab [NUM_SENSORS];

	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_unit
		localparam logic [31:0] ANG = 32'((64'(g) << 32) / NUM_SENSORS);
		localparam logic [2*UNIT_W-1:0] CS = unit_vec(ANG);
		assign cos_tab[g] = $signed(CS[2*UNIT_W-1:UNIT_W]);
		assign sin_tab[g] = $signed(CS[UNIT_W-1:0]);
	end

	state_t                          state_q;
	logic [NUM_SENSORS-1:0][DIST_W-1:0] dist_q;
	logic [SEL_W-1:0]                idx_q;
	logic signed [SUM_W-1:0]         sx_q;
	logic signed [SUM_W-1:0]         sy_q;
	logic [DIST_W-1:0]               best_val_q;
	logic [SEL_W-1:0]                best_q;
	logic signed [CW-1:0]            x_q;
	logic signed [CW-1:0]            y_q;
	logic signed [ACC_W-1:0]         acc_q;
	logic [STEP_W-1:0]               k_q;
	logic signed [DIR_W-1:0]         dir_q;

	logic [DIST_W-1:0]        d;
	logic [DIST_W-1:0]        c;
	logic signed [DIST_W:0]   cs;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [CW-1:0]     xw;
	logic signed [CW-1:0]     yw;
	logic signed [CW-1:0]     xs;
	logic signed [CW-1:0]     ys;
	logic signed [ACC_W-1:0]  atan_k;
	logic [ACC_W-1:0]         mag;
	logic [ACC_W+8:0]         deg_prod;
	logic [ACC_W-24:0]        deg_raw;
	logic [DIR_W-1:0]         deg_sat;
	logic [DIR_W-1:0]         deg_val;

	always_comb begin
		d      = dist_q[idx_q];
		c      = (d > distance_limit) ? distance_limit : d;
		cs     = $signed({1'b0, c});
		prod_x = cs * cos_tab[idx_q];
		prod_y = cs * sin_tab[idx_q];

		xw = $signed({{(CW - SUM_W - VEC_SCALE_SHIFT){sx_q[SUM_W-1]}}, sx_q,
			{VEC_SCALE_SHIFT{1'b0}}});
		yw = $signed({{(CW - SUM_W - VEC_SCALE_SHIFT){sy_q[SUM_W-1]}}, sy_q,
			{VEC_SCALE_SHIFT{1'b0}}});

		xs     = x_q >>> k_q;
		ys     = y_q >>> k_q;
		atan_k = $signed({2'b00, TURN_ATAN[k_q]});

		mag      = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		deg_prod = (ACC_W + 9)'(mag) * (ACC_W + 9)'(DEG_PER_TURN);
		deg_raw  = deg_prod[ACC_W+8:32];
		deg_sat  = (deg_raw > (ACC_W - 23)'(DEG_LIMIT)) ? DEG_LIMIT : deg_raw[DIR_W-1:0];
		deg_val  = acc_q[ACC_W-1] ? (~deg_sat + DIR_W'(1)) : deg_sat;
	end

	assign pop_ready          = (state_q == S_IDLE);
	assign res.valid          = (state_q == S_OUT);
	assign res.safe_direction = dir_q;
	assign res.nearest_sensor = IDX_W'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dist_q     <= '0;
			idx_q      <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			best_val_q <= '0;
			best_q     <= '0;
			x_q        <= '0;
			y_q        <= '0;
			acc_q      <= '0;
			k_q        <= '0;
			dir_q      <= DIR_ZERO;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						dist_q     <= pop_frame;
						idx_q      <= '0;
						sx_q       <= '0;
						sy_q       <= '0;
						best_val_q <= pop_frame[0];
						best_q     <= '0;
						state_q    <= S_SUM;
					end
				end
				S_SUM: begin
					sx_q <= sx_q + SUM_W'(prod_x);
					sy_q <= sy_q + SUM_W'(prod_y);
					if (d < best_val_q) begin
						best_val_q <= d;
						best_q     <= idx_q;
					end
					if (idx_q == SEL_LAST) begin
						state_q <= S_PREP;
					end else begin
						idx_q <= idx_q + SEL_W'(1);
					end
				end
				S_PREP: begin
					k_q <= '0;
					if (sy_q == '0) begin
						dir_q   <= sx_q[SUM_W-1] ? DIR_HALF : DIR_ZERO;
						state_q <= S_OUT;
					end else if (sx_q == '0) begin
						dir_q   <= sy_q[SUM_W-1] ? -DIR_QUARTER : DIR_QUARTER;
						state_q <= S_OUT;
					end else begin
						// Left half plane: turn a quarter first so the
						// vectoring pass starts with x positive.
						if (sx_q[SUM_W-1]) begin
							if (!sy_q[SUM_W-1]) begin
								x_q   <= yw;
								y_q   <= -xw;
								acc_q <= QUARTER_TURN;
							end else begin
								x_q   <= -yw;
								y_q   <= xw;
								acc_q <= -QUARTER_TURN;
							end
						end else begin
							x_q   <= xw;
							y_q   <= yw;
							acc_q <= '0;
						end
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (y_q > 0) begin
						x_q   <= x_q + ys;
						y_q   <= y_q - xs;
						acc_q <= acc_q + atan_k;
					end else begin
						x_q   <= x_q - ys;
						y_q   <= y_q + xs;
						acc_q <= acc_q - atan_k;
					end
					if (k_q == STEP_LAST) begin
						state_q <= S_DEG;
					end else begin
						k_q <= k_q + STEP_W'(1);
					end
				end
				S_DEG: begin
					dir_q   <= $signed(deg_val);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/range_frame_safe_direction_unit.sv =====
// ----------------------------------------------------------------------------
// Range frame safe direction unit
// Parses range sensor frames from a byte stream and reports, for each frame
// with a good trailer, the safe direction in degrees and the nearest sensor.
//
// Bytes arrive on rx, one per beat. A frame is the header 0xFF, one distance
// byte per sensor of the ring, then the trailer 0xAA; bytes outside a frame
// are skipped and a frame with a bad trailer is dropped without a result.
// Each good frame yields one beat on res: safe_direction is the angle, in
// whole degrees truncated toward zero, of the sum of the distances (each
// clamped to distance_limit) weighted by the unit vectors of the sensors,
// which sit evenly round the ring starting at zero degrees; nearest_sensor
// is the index of the first sensor with the smallest raw distance. The
// parser takes one byte per cycle and only holds rx.ready low on a trailer
// beat while both frame queue entries are taken. The direction engine works
// on one frame at a time: it loads the frame, multiply-accumulates the
// sensors one after another, sets up, runs 20 CORDIC vectoring iterations
// and converts the angle to whole degrees; a sum that lies on an axis skips
// the iterations and the conversion. The engine takes no new frame until
// the result beat has been taken. The result waits in the output register
// until taken, while the parser goes on accepting bytes. distance_limit
// resets to 255 and is written through cfg_valid/cfg_ready/cfg_data; the
// user must write it only while idle, which the block itself does not
// enforce.
// ----------------------------------------------------------------------------
`include "range_frame_safe_direction_unit_assert.svh"

module range_frame_safe_direction_unit import rfsd_pkg::*; #(
	parameter int unsigned NUM_SENSORS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	rfsd_byte_if.sink         rx,
	rfsd_dir_if.source        res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DIST_W-1:0] cfg_data
);

	localparam int unsigned FRAME_W = NUM_SENSORS * DIST_W;

	// Configuration: a single register, always ready for a write beat.
	logic [DIST_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Front to queue: a whole frame moves in a single beat on its trailer.
	logic                               push_valid;
	logic                               push_ready;
	logic [NUM_SENSORS-1:0][DIST_W-1:0] push_frame;

	// Queue to back: the engine pops one frame when it is idle.
	logic                               pop_valid;
	logic                               pop_ready;
	logic [FRAME_W-1:0]                 pop_data;
	logic [NUM_SENSORS-1:0][DIST_W-1:0] pop_frame;

	assign pop_frame = pop_data;

	rfsd_front #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame)
	);

	rfsd_queue #(
		.WIDTH (FRAME_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_frame),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rfsd_back #(
		.NUM_SENSORS (NUM_SENSORS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_frame      (pop_frame),
		.distance_limit (limit_q),
		.res            (res)
	);

	// The parser must never offer a frame that the queue cannot take.
	`RFSD_ASSERT_SAME(a_push_fits, push_valid, push_ready, "frame pushed into a full queue")

	// The byte channel only stalls because the queue is full.
	`RFSD_ASSERT_SAME(a_stall_cause, !rx.ready, !push_ready, "byte channel stalled with queue room")

	// Once the engine takes a frame it is busy and shows no result next cycle.
	`RFSD_ASSERT_NEXT(a_pop_busy, pop_valid && pop_ready, !res.valid, "result right after a pop")

endmodule

// ===== tb/rfsd_direction_checker.sv =====
// ----------------------------------------------------------------------------
// Safe direction checker
// Watches the byte, result and limit channels of the unit, follows the frame
// parser, works out the direction and nearest sensor of each good frame in
// fixed point, and compares every result beat with the oldest outstanding one.
// ----------------------------------------------------------------------------
module rfsd_direction_checker import rfsd_pkg::*; #(
	parameter int unsigned SENSORS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	rfsd_byte_if              rx,
	rfsd_dir_if               res,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [DIST_W-1:0] cfg_data,
	output int                mismatch_count,
	output int                pending_frames
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint TURN_QUARTER = 64'sd1073741824;
	localparam longint TURN_HALF    = 64'sd2147483648;
	localparam longint TURN_FULL    = 64'sd4294967296;
	localparam longint UNIT_GAIN    = 64'sd652032874;
	localparam int     REPORT_LIMIT = 10;

	localparam longint STEP_ANGLE [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465,  10679838,  5340245,   2670163,  1335087,
		667544,    333772,    166886,    83443,    41722,
		20861,     10430,     5215,      2608,     1304
	};

	typedef struct packed {
		logic signed [DIR_W-1:0] dir;
		logic [IDX_W-1:0]        nearest;
	} heading_t;

	longint            ring_cos [SENSORS];
	longint            ring_sin [SENSORS];
	logic [DIST_W-1:0] clamp_limit;
	logic [3:0]        frame_pos;
	logic [DIST_W-1:0] ranges [SENSORS];
	heading_t          expected_headings [$];
	int                fails;

	// Cosine and sine of sensor i in Q2.14, by CORDIC rotation of its angle
	// after folding it into the right half plane.
	task automatic sensor_axis(input int i, output longint c, output longint s);
		longint z, x, y, xs, ys;
		bit flip;
		z = (longint'(i) <<< 32) / longint'(SENSORS);
		x = UNIT_GAIN;
		y = 0;
		flip = 1'b0;
		if (z >= TURN_HALF)
			z = z - TURN_FULL;
		if (z > TURN_QUARTER) begin
			z = z - TURN_HALF;
			flip = 1'b1;
		end else if (z < -TURN_QUARTER) begin
			z = z + TURN_HALF;
			flip = 1'b1;
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - STEP_ANGLE[k];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + STEP_ANGLE[k];
			end
		end
		x = (x + 32768) >>> 16;
		y = (y + 32768) >>> 16;
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Angle of (x, y) in whole degrees, truncated toward zero.
	function automatic int vector_heading(input longint x, input longint y);
		longint acc, t, xs, ys, mag, deg;
		acc = 0;
		if (y == 0)
			return (x < 0) ? 180 : 0;
		if (x == 0)
			return (y > 0) ? 90 : -90;
		x = x * 1048576;
		y = y * 1048576;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				acc = TURN_QUARTER;
			end else begin
				x = -y;
				y = t;
				acc = -TURN_QUARTER;
			end
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + STEP_ANGLE[k];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - STEP_ANGLE[k];
			end
		end
		mag = (acc < 0) ? -acc : acc;
		deg = (mag * 360) >>> 32;
		if (deg > 180)
			deg = 180;
		return (acc < 0) ? -int'(deg) : int'(deg);
	endfunction

	function automatic heading_t predict_frame();
		heading_t r;
		longint sx, sy;
		logic [DIST_W-1:0] c, low;
		int best;
		sx = 0;
		sy = 0;
		best = 0;
		low = ranges[0];
		for (int i = 0; i < SENSORS; i++) begin
			c = (ranges[i] > clamp_limit) ? clamp_limit : ranges[i];
			sx = sx + longint'(c) * ring_cos[i];
			sy = sy + longint'(c) * ring_sin[i];
			if (ranges[i] < low) begin
				low = ranges[i];
				best = i;
			end
		end
		r.dir = DIR_W'(vector_heading(sx, sy));
		r.nearest = IDX_W'(best);
		return r;
	endfunction

	initial begin
		for (int i = 0; i < SENSORS; i++)
			sensor_axis(i, ring_cos[i], ring_sin[i]);
	end

	always @(posedge clk or negedge arst_n) begin
		heading_t want;
		if (!arst_n) begin
			clamp_limit = LIMIT_RESET;
			frame_pos = '0;
			expected_headings.delete();
			fails = 0;
		end else begin
			// Results first, so that a trailer in the same cycle cannot be
			// matched against its own, not yet computed, result.
			if (res.valid && res.ready) begin
				if (expected_headings.size() == 0) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("[%0t] unexpected result beat: dir %0d nearest %0d",
							$time, $signed(res.safe_direction), res.nearest_sensor);
				end else begin
					want = expected_headings.pop_front();
					if (res.safe_direction !== want.dir
							|| res.nearest_sensor !== want.nearest) begin
						fails++;
						if (fails <= REPORT_LIMIT)
							$display("[%0t] result mismatch: expected dir %0d nearest %0d, got dir %0d nearest %0d",
								$time, $signed(want.dir), want.nearest,
								$signed(res.safe_direction), res.nearest_sensor);
					end
				end
			end
			if (rx.valid && rx.ready) begin
				if (frame_pos == 0) begin
					if (rx.rx_byte == FRAME_HEADER)
						frame_pos = 1;
				end else if (frame_pos <= SENSORS) begin
					ranges[frame_pos - 1] = rx.rx_byte;
					frame_pos = frame_pos + 1;
				end else begin
					frame_pos = '0;
					if (rx.rx_byte == FRAME_TRAILER)
						expected_headings.push_back(predict_frame());
				end
			end
			if (cfg_valid && cfg_ready)
				clamp_limit = cfg_data;
		end
		mismatch_count <= fails;
		pending_frames <= expected_headings.size();
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Range frame safe direction testbench
// Feeds the unit a byte stream of sensor frames, broken frames and noise
// under several distance limits, with random gaps on both channels, and
// leaves the checking of every result to the direction checker.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rfsd_pkg::*;

	localparam int unsigned SENSORS = 7;
	// Stimulus size and pacing.
	localparam int RANDOM_BYTES  = 1900;
	localparam int PHASES        = 8;
	localparam int MAX_GAP       = 9;
	// The long receiver hold-off, used once to fill the frame queue.
	localparam int HOLD_CYCLES   = 1500;
	localparam int HOLD_FRAMES   = 10;
	// Quiet time after the last result.
	localparam int SETTLE_CYCLES = SENSORS + 40;
	// Abandon the run after 2 ms, far beyond the slowest correct run.
	localparam int TIMEOUT_NS    = 2000000;

	typedef logic [DIST_W-1:0] ring_t [SENSORS];

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [DIST_W-1:0] cfg_data;
	int                mismatch_count;
	int                pending_frames;

	// Shared between the two stimulus processes: brisk removes all idling,
	// and each increment of hold_asks asks the receiver for one long hold-off.
	bit brisk = 1'b0;
	int hold_asks = 0;
	int frame_bytes = 0;

	rfsd_byte_if rx_if ();
	rfsd_dir_if  res_if ();

	always #2 clk = ~clk;

	range_frame_safe_direction_unit #(.NUM_SENSORS(SENSORS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	rfsd_direction_checker #(.SENSORS(SENSORS)) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx             (rx_if),
		.res            (res_if),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_frames (pending_frames)
	);

	// Offer one byte after a random gap and return at the edge where it is
	// taken. With no gap valid simply stays high, so it is never lowered and
	// raised again within one time step.
	task automatic put_byte(input logic [DIST_W-1:0] b);
		int gap;
		gap = brisk ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
	endtask

	task automatic put_frame(input ring_t d, input logic [DIST_W-1:0] tail);
		put_byte(FRAME_HEADER);
		for (int i = 0; i < SENSORS; i++)
			put_byte(d[i]);
		put_byte(tail);
		frame_bytes += SENSORS + 2;
	endtask

	// Stop sending and wait for every outstanding result. The checker's
	// count is registered, hence the edge before the first look.
	task automatic await_idle(input int extra);
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_frames != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_limit(input logic [DIST_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Distance patterns: mostly uniform, with shapes that bring out ties in
	// the nearest sensor, sums on or near an axis, and the zero vector.
	function automatic void random_ring(output ring_t d);
		int shape;
		logic [DIST_W-1:0] v;
		shape = $urandom_range(0, 9);
		v = DIST_W'($urandom);
		for (int i = 0; i < SENSORS; i++) begin
			case (shape)
				5: d[i] = v;
				6: d[i] = (i == 0) ? v : '0;
				7: d[i] = DIST_W'($urandom);
				8: d[i] = $urandom_range(0, 1) ? '1 : '0;
				9: d[i] = DIST_W'($urandom_range(0, 15));
				default: d[i] = DIST_W'($urandom);
			endcase
		end
		// Mirror the ring about sensor 0, which cancels the sine terms.
		if (shape == 7)
			for (int i = 1; i < SENSORS; i++)
				d[i] = d[SENSORS - i];
		// Now and then rotate a single echo to another sensor.
		if (shape == 6 && $urandom_range(0, 1)) begin
			d[0] = '0;
			d[$urandom_range(0, SENSORS - 1)] = v;
		end
	endfunction

	// The receiver: a random stall before each result beat, or the long
	// hold-off when one has been asked for, counted here in cycles.
	initial begin : result_sink
		int stall;
		int hold_seen;
		hold_seen = 0;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = brisk ? 0 : $urandom_range(0, MAX_GAP);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				stall = HOLD_CYCLES;
			end
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	// The sender, which also gives the verdict.
	initial begin : byte_source
		ring_t ring;
		logic [DIST_W-1:0] tail;
		logic [DIST_W-1:0] limit_plan [PHASES];
		logic [DIST_W-1:0] limit_value;
		int pick;
		int quota;
		limit_plan = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd254, 8'd0, 8'd0, 8'd200};

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset limit. A stray byte and a stray
		// trailer while waiting for a header are both skipped.
		put_byte(8'h00);
		put_byte(FRAME_TRAILER);
		// All distances zero: the zero vector, and a tie for nearest.
		ring = '{default: '0};
		put_frame(ring, FRAME_TRAILER);
		// A single full-scale echo on sensor 0: the sum lies on the x axis.
		ring[0] = '1;
		put_frame(ring, FRAME_TRAILER);
		// Header and trailer codes as distances, then a bad trailer, which
		// must drop the frame without a result.
		ring = '{8'hAA, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h00};
		put_frame(ring, 8'hAB);

		// Random part, in phases with a fresh distance limit each.
		for (int phase = 0; phase < PHASES; phase++) begin
			await_idle(SETTLE_CYCLES);
			limit_value = (phase == 5 || phase == 6) ? DIST_W'($urandom) : limit_plan[phase];
			set_limit(limit_value);

			if (phase == 2) begin
				// Back-to-back good frames while the receiver holds off, so
				// that the frame queue fills and the byte channel stalls.
				brisk = 1'b1;
				hold_asks++;
				repeat (HOLD_FRAMES) begin
					random_ring(ring);
					put_frame(ring, FRAME_TRAILER);
				end
				brisk = 1'b0;
			end
			// One phase runs with no idling on either side.
			brisk = (phase == 5);

			quota = RANDOM_BYTES * (phase + 1) / PHASES;
			while (frame_bytes < quota) begin
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					random_ring(ring);
					put_frame(ring, FRAME_TRAILER);
				end else if (pick < 92) begin
					random_ring(ring);
					do tail = DIST_W'($urandom); while (tail == FRAME_TRAILER);
					put_frame(ring, tail);
				end else if (pick < 96) begin
					// Noise between frames; a 0xFF in it opens a frame that
					// the following bytes then fill.
					repeat ($urandom_range(1, 3))
						put_byte(DIST_W'($urandom));
				end else begin
					// A frame cut short: the next header becomes a distance
					// and the parser has to find its way back.
					put_byte(FRAME_HEADER);
					repeat ($urandom_range(1, SENSORS - 1))
						put_byte(DIST_W'($urandom));
					frame_bytes += 1;
				end
				// Occasionally let everything drain before going on.
				if ($urandom_range(0, 59) == 0)
					await_idle(0);
			end
			brisk = 1'b0;
		end

		await_idle(SETTLE_CYCLES);
		if (mismatch_count == 0 && pending_frames == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rfsd_pkg.sv
rtl/rfsd_byte_if.sv
rtl/rfsd_dir_if.sv
rtl/rfsd_front.sv
rtl/rfsd_queue.sv
rtl/rfsd_back.sv
rtl/range_frame_safe_direction_unit.sv
tb/rfsd_direction_checker.sv
tb/tb.sv
